/* src/mclb_pkg.sv */
// mclb_pkg: shared types and constants for the multi-channel led blinker
// request and response structs, request kinds, default sizes; no dependencies
package mclb_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    localparam int COUNT_BITS  = 16;
    localparam int ON_BITS     = 16;
    localparam int PERIOD_BITS = 17;
    localparam int MASK_BITS   = 8;

    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_STOP     = 2'd1,
        KIND_STOP_ALL = 2'd2,
        KIND_TICK     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [2:0]             channel;
        logic [COUNT_BITS-1:0]  repeat_count;
        logic [ON_BITS-1:0]     on_time;
        logic [ON_BITS-1:0]     off_time;
    } t_req;

    typedef struct packed {
        logic [MASK_BITS-1:0] lit_mask;
        logic [MASK_BITS-1:0] active_mask;
    } t_rsp;

endpackage

/* src/mclb_div.sv */
// mclb_div: restoring divider, one quotient bit per cycle
// divides a DW-bit elapsed time by a period; depends on mclb_pkg
module mclb_div #(
    parameter int DW = mclb_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [DW-1:0]                   i_dividend,
    input  logic [mclb_pkg::PERIOD_BITS-1:0] i_divisor,
    output logic                            o_done,
    output logic [DW-1:0]                   o_quot,
    output logic [mclb_pkg::PERIOD_BITS-1:0] o_rem
);
    localparam int PB = mclb_pkg::PERIOD_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quot, n_quot;
    logic [PB-1:0] r_rem, n_rem;
    logic [PB-1:0] r_div, n_div;

    logic [PB:0]   rem_sh;
    logic [PB:0]   rem_sub;
    logic          ge;

    assign rem_sh  = {r_rem, r_quot[DW-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // dividend bits shift out the top while quotient bits enter below
            n_quot = {r_quot[DW-2:0], ge};
            n_rem  = ge ? rem_sub[PB-1:0] : rem_sh[PB-1:0];
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* src/multi_channel_led_blinker.sv */
// multi_channel_led_blinker: top level of the led blink pattern generator
// holds the channel state and the sequencer; uses mclb_pkg and mclb_div
//
// usage:
//   request channel (i_req_valid / o_req_stall / i_req) carries start, stop,
//   stop-all and tick requests. response channel (o_rsp_valid / i_rsp_stall /
//   o_rsp) returns the lit mask and active mask once per request.
// request handling:
//   start, stop and stop-all pass from ST_IDLE to ST_DONE, which loads the masks
//   into the response register. a tick steps ST_SCAN past each idle channel;
//   for each active channel ST_DIV runs its elapsed time through the one shared
//   bit-serial divider, channel after channel, and then the tick ends in ST_DONE.
//   one request is in work at a time; o_req_stall is high meanwhile.
// reset:
//   synchronous active-low reset stops all channels, clears the time counter
//   and drops any pending response.
// stall:
//   the response sits in an output register; a new request is taken while it
//   waits, and its response is held back until the old one is taken.
module multi_channel_led_blinker #(
    parameter int NUM_CHANNELS = mclb_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = mclb_pkg::TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  mclb_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output mclb_pkg::t_rsp o_rsp
);
    localparam int N   = NUM_CHANNELS;
    localparam int TB  = TIME_BITS;
    localparam int CB  = mclb_pkg::COUNT_BITS;
    localparam int OB  = mclb_pkg::ON_BITS;
    localparam int PB  = mclb_pkg::PERIOD_BITS;
    localparam int MB  = mclb_pkg::MASK_BITS;
    localparam int CHW = (N > 1) ? $clog2(N) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [TB-1:0]   r_time, n_time;
    logic [CHW-1:0]  r_chan, n_chan;
    logic [N-1:0]    r_active, n_active;
    logic [N-1:0]    r_lit, n_lit;
    logic [CB-1:0]   r_count [N];
    logic [CB-1:0]   n_count [N];
    logic [OB-1:0]   r_on [N];
    logic [OB-1:0]   n_on [N];
    logic [PB-1:0]   r_period [N];
    logic [PB-1:0]   n_period [N];
    logic [TB-1:0]   r_start [N];
    logic [TB-1:0]   n_start [N];
    mclb_pkg::t_rsp  r_rsp, n_rsp;
    logic            r_rsp_valid, n_rsp_valid;

    logic [7:0]      ch_ext;
    logic            ch_ok;
    logic [CHW-1:0]  ch_idx;
    logic            chan_last;
    logic [PB-1:0]   period_eff;
    logic [MB-1:0]   lit8;
    logic [MB-1:0]   act8;

    logic            div_start;
    logic            div_done;
    logic [TB-1:0]   div_quot;
    logic [PB-1:0]   div_rem;

    assign ch_ext    = {5'b0, i_req.channel};
    assign ch_ok     = 32'(i_req.channel) < N;
    assign ch_idx    = ch_ext[CHW-1:0];
    assign chan_last = 32'(r_chan) == N - 1;
    // a zero period never comes from a start; treat it as one
    assign period_eff = (r_period[r_chan] == '0) ? PB'(1) : r_period[r_chan];

    for (genvar g = 0; g < MB; g++) begin : g_mask
        if (g < N) begin : g_on
            assign lit8[g] = r_lit[g];
            assign act8[g] = r_active[g];
        end else begin : g_off
            assign lit8[g] = 1'b0;
            assign act8[g] = 1'b0;
        end
    end

    mclb_div #(
        .DW (TB)
    ) u_mclb_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_time - r_start[r_chan]),
        .i_divisor  (period_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_chan      = r_chan;
        n_active    = r_active;
        n_lit       = r_lit;
        n_count     = r_count;
        n_on        = r_on;
        n_period    = r_period;
        n_start     = r_start;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_DONE;
                    unique case (i_req.kind)
                        mclb_pkg::KIND_START: begin
                            if (ch_ok && !r_active[ch_idx] && i_req.repeat_count != '0
                                    && i_req.on_time != '0) begin
                                n_count[ch_idx]  = i_req.repeat_count;
                                n_on[ch_idx]     = i_req.on_time;
                                n_period[ch_idx] = {1'b0, i_req.on_time}
                                                 + {1'b0, i_req.off_time};
                                n_start[ch_idx]  = r_time;
                                n_active[ch_idx] = 1'b1;
                                n_lit[ch_idx]    = 1'b1;
                            end
                        end
                        mclb_pkg::KIND_STOP: begin
                            if (ch_ok) begin
                                n_active[ch_idx] = 1'b0;
                                n_lit[ch_idx]    = 1'b0;
                            end
                        end
                        mclb_pkg::KIND_STOP_ALL: begin
                            n_active = '0;
                            n_lit    = '0;
                        end
                        mclb_pkg::KIND_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_chan  = '0;
                            n_state = ST_SCAN;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_active[r_chan]) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (chan_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_chan = r_chan + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_lit[r_chan] = div_rem < {1'b0, r_on[r_chan]};
                    // all periods done: channel stops by itself
                    if (div_quot >= TB'(r_count[r_chan])) begin
                        n_active[r_chan] = 1'b0;
                        n_lit[r_chan]    = 1'b0;
                    end
                    if (chan_last) begin
                        n_state = ST_DONE;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp.lit_mask    = lit8;
                    n_rsp.active_mask = act8;
                    n_rsp_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time      <= '0;
            r_chan      <= '0;
            r_active    <= '0;
            r_lit       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_chan      <= n_chan;
            r_active    <= n_active;
            r_lit       <= n_lit;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_on     <= n_on;
        r_period <= n_period;
        r_start  <= n_start;
        r_rsp    <= n_rsp;
    end

    assign o_req_stall = r_state != ST_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* src/mclb_checker.sv */
// mclb_checker: port-level assertions for the multi-channel led blinker
// bound to multi_channel_led_blinker; depends on mclb_pkg
module mclb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input mclb_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input mclb_pkg::t_rsp o_rsp
);
    // a led is never lit on a channel that is not running
    a_lit_in_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.lit_mask & ~o_rsp.active_mask) == '0)
        else $error("lit channel outside active mask");

    // one request at a time: taking a request closes the request side
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("request side open right after a request");

    // nothing pending right out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && !o_req_stall)
        else $error("state not cleared by reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_stall) |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

endmodule

bind multi_channel_led_blinker mclb_checker u_mclb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

/* dv/multi_channel_led_blinker_test.sv */
`timescale 1ns / 100ps
// multi_channel_led_blinker_test: self-checking testbench for the led blinker
// depends on mclb_pkg and multi_channel_led_blinker; drives requests, predicts masks
module multi_channel_led_blinker_test;

    localparam int  NCH          = 8;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  RANDOM_ITEMS = 1800;
    localparam time RUN_LIMIT    = 40_000_000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_stall;
    mclb_pkg::t_req i_req;
    logic           o_rsp_valid;
    logic           i_rsp_stall;
    mclb_pkg::t_rsp o_rsp;

    // blinker state as the testbench sees it
    logic [31:0] time_count;
    logic        ch_active [NCH];
    logic        ch_lit    [NCH];
    logic [15:0] ch_count  [NCH];
    logic [15:0] ch_on     [NCH];
    logic [16:0] ch_period [NCH];
    logic [31:0] ch_start  [NCH];

    mclb_pkg::t_rsp pending_masks[$];
    int   mismatch_count = 0;
    bit   req_steady     = 1'b0;
    bit   rsp_steady     = 1'b0;
    int   hold_left      = 0;

    multi_channel_led_blinker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_chan(input int c);
        ch_active[c] = 1'b0;
        ch_lit[c]    = 1'b0;
        ch_count[c]  = '0;
        ch_on[c]     = '0;
        ch_period[c] = 17'd1;
        ch_start[c]  = '0;
    endfunction

    function automatic void reset_model();
        time_count = '0;
        for (int c = 0; c < NCH; c++)
            clear_chan(c);
    endfunction

    // applies one request to the model state and returns the masks it leaves
    function automatic mclb_pkg::t_rsp predict_masks(input mclb_pkg::t_req r);
        mclb_pkg::t_rsp m;
        logic [31:0]    elapsed;
        logic [31:0]    period;
        int             ch;
        ch = int'(r.channel);
        case (r.kind)
            mclb_pkg::KIND_START: begin
                if (!ch_active[ch] && r.repeat_count != 0 && r.on_time != 0) begin
                    ch_count[ch]  = r.repeat_count;
                    ch_on[ch]     = r.on_time;
                    ch_period[ch] = {1'b0, r.on_time} + {1'b0, r.off_time};
                    ch_start[ch]  = time_count;
                    ch_active[ch] = 1'b1;
                    ch_lit[ch]    = 1'b1;
                end
            end
            mclb_pkg::KIND_STOP: clear_chan(ch);
            mclb_pkg::KIND_STOP_ALL: begin
                for (int c = 0; c < NCH; c++)
                    clear_chan(c);
            end
            default: begin
                // time moves first, then each running channel looks at the new time
                time_count = time_count + 32'd1;
                for (int c = 0; c < NCH; c++) begin
                    if (ch_active[c]) begin
                        elapsed   = time_count - ch_start[c];
                        period    = (ch_period[c] == 0) ? 32'd1 : {15'd0, ch_period[c]};
                        ch_lit[c] = (elapsed % period) < {16'd0, ch_on[c]};
                        if (elapsed / period >= {16'd0, ch_count[c]})
                            clear_chan(c);
                    end
                end
            end
        endcase
        for (int c = 0; c < NCH; c++) begin
            m.lit_mask[c]    = ch_lit[c];
            m.active_mask[c] = ch_active[c];
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: mismatch in %s: expected %02h, got %02h", $time, what, want, got);
        mismatch_count++;
    endtask

    // response side: random stall, long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_rsp_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else if (rsp_steady) begin
            i_rsp_stall = 1'b0;
        end else begin
            i_rsp_stall = ($urandom_range(0, 99) < 22);
        end
    end

    always @(posedge i_clk) begin
        mclb_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (pending_masks.size() == 0) begin
                report_mismatch("response with no request outstanding", 8'h00,
                                o_rsp.active_mask);
            end else begin
                want = pending_masks.pop_front();
                if (o_rsp.lit_mask !== want.lit_mask)
                    report_mismatch("lit_mask", want.lit_mask, o_rsp.lit_mask);
                if (o_rsp.active_mask !== want.active_mask)
                    report_mismatch("active_mask", want.active_mask, o_rsp.active_mask);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_req(input mclb_pkg::t_req r);
        mclb_pkg::t_rsp want;
        if (!req_steady)
            while ($urandom_range(0, 99) < 22) @(negedge i_clk);
        i_req       = r;
        i_req_valid = 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        want = predict_masks(r);
        pending_masks.push_back(want);
        @(negedge i_clk);
        i_req_valid = 1'b0;
    endtask

    task automatic send_op(input mclb_pkg::t_kind k, input int ch, input int cnt,
                           input int on, input int off);
        mclb_pkg::t_req r;
        r.kind         = k;
        r.channel      = ch[2:0];
        r.repeat_count = cnt[15:0];
        r.on_time      = on[15:0];
        r.off_time     = off[15:0];
        send_req(r);
    endtask

    task automatic wait_drained();
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly short blink runs and ticks so channels finish on their own
    function automatic mclb_pkg::t_req make_rand_req();
        mclb_pkg::t_req r;
        int             pick;
        pick           = $urandom_range(0, 99);
        r.kind         = mclb_pkg::KIND_TICK;
        r.channel      = 3'($urandom_range(0, NCH - 1));
        r.repeat_count = 16'($urandom_range(1, 4));
        r.on_time      = 16'($urandom_range(1, 6));
        r.off_time     = 16'($urandom_range(0, 6));
        if (pick < 55) begin
            r.kind = mclb_pkg::KIND_TICK;
        end else if (pick < 80) begin
            r.kind = mclb_pkg::KIND_START;
        end else if (pick < 86) begin
            r.kind         = mclb_pkg::KIND_START;
            r.repeat_count = 16'($urandom);
            r.on_time      = 16'($urandom);
            r.off_time     = 16'($urandom);
        end else if (pick < 93) begin
            r.kind = mclb_pkg::KIND_STOP;
        end else if (pick < 95) begin
            r.kind = mclb_pkg::KIND_STOP_ALL;
        end else begin
            r              = mclb_pkg::t_req'($urandom);
            r.kind         = mclb_pkg::t_kind'($urandom_range(0, 3));
            r.repeat_count = 16'($urandom);
            r.off_time     = 16'($urandom);
        end
        return r;
    endfunction

    task automatic test_idle_requests();
        send_op(mclb_pkg::KIND_TICK, 0, 0, 0, 0);
        send_op(mclb_pkg::KIND_STOP, 3, 0, 0, 0);
        send_op(mclb_pkg::KIND_STOP_ALL, 0, 0, 0, 0);
    endtask

    task automatic test_ignored_starts();
        send_op(mclb_pkg::KIND_START, 2, 0, 5, 5);
        send_op(mclb_pkg::KIND_START, 2, 3, 0, 5);
    endtask

    task automatic test_field_extremes();
        send_op(mclb_pkg::KIND_START, 7, 16'hffff, 16'hffff, 16'hffff);
        send_op(mclb_pkg::KIND_START, 0, 1, 1, 0);
        // busy channel keeps its old settings
        send_op(mclb_pkg::KIND_START, 7, 1, 1, 0);
        send_op(mclb_pkg::KIND_TICK, 0, 0, 0, 0);
        send_op(mclb_pkg::KIND_TICK, 0, 0, 0, 0);
        send_op(mclb_pkg::KIND_STOP, 7, 0, 0, 0);
    endtask

    task automatic test_blink_sequence();
        send_op(mclb_pkg::KIND_START, 5, 2, 2, 1);
        send_op(mclb_pkg::KIND_START, 1, 1, 3, 0);
        repeat (7) send_op(mclb_pkg::KIND_TICK, 0, 0, 0, 0);
        send_op(mclb_pkg::KIND_STOP_ALL, 0, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        hold_left = 2000;
        repeat (24) send_req(make_rand_req());
        // sender pauses here until every response is back
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // one stretch with no idling on either side
            req_steady = (sent >= 600 && sent < 900);
            rsp_steady = req_steady;
            send_req(make_rand_req());
            sent++;
            if (sent == 1200)
                wait_drained();
        end
        req_steady = 1'b0;
        rsp_steady = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        i_rsp_stall = 1'b0;
        reset_model();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_requests();
        test_ignored_starts();
        test_field_extremes();
        test_blink_sequence();
        wait_drained();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/mclb_pkg.sv
src/mclb_div.sv
src/multi_channel_led_blinker.sv
src/mclb_checker.sv
dv/multi_channel_led_blinker_test.sv
